// File: hdl/arx_keystream_xor_cipher_macros.svh
// Assertion macros used by the cipher controller
`ifndef ARX_KEYSTREAM_XOR_CIPHER_MACROS_SVH
`define ARX_KEYSTREAM_XOR_CIPHER_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define AKX_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("violated");
// implication whose consequent is checked in the cycle after the antecedent
`define AKX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("violated");
`endif

// File: hdl/akx_pkg.sv
// Package: shared types and constants for the ARX keystream cipher
package akx_pkg;
    localparam logic [31:0] MAGIC_LO = 32'h4D216F73;
    localparam logic [31:0] MAGIC_HI = 32'h63316734;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_2 = 3'd6;

    typedef struct packed {
        logic load;
        logic step;
        logic add_init;
        logic [3:0] shuffle;
    } akx_cmd_t;

    typedef struct packed {
        logic last_step;
        logic last_shuffle;
    } akx_status_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

    // quad indices; shuffles 0-7 first round, 8-15 second
    function automatic logic [15:0] quad(input logic [3:0] k);
        case (k)
            4'd0: quad = {4'd3, 4'd2, 4'd1, 4'd0};
            4'd1: quad = {4'd7, 4'd6, 4'd5, 4'd4};
            4'd2: quad = {4'd11, 4'd10, 4'd9, 4'd8};
            4'd3: quad = {4'd15, 4'd14, 4'd13, 4'd12};
            4'd4: quad = {4'd15, 4'd10, 4'd5, 4'd0};
            4'd5: quad = {4'd12, 4'd11, 4'd6, 4'd1};
            4'd6: quad = {4'd13, 4'd8, 4'd7, 4'd2};
            4'd7: quad = {4'd14, 4'd9, 4'd4, 4'd3};
            4'd8: quad = {4'd12, 4'd8, 4'd4, 4'd0};
            4'd9: quad = {4'd13, 4'd9, 4'd5, 4'd1};
            4'd10: quad = {4'd14, 4'd10, 4'd6, 4'd2};
            4'd11: quad = {4'd15, 4'd11, 4'd7, 4'd3};
            4'd12: quad = {4'd12, 4'd9, 4'd6, 4'd3};
            4'd13: quad = {4'd15, 4'd8, 4'd5, 4'd2};
            4'd14: quad = {4'd14, 4'd11, 4'd4, 4'd1};
            4'd15: quad = {4'd13, 4'd10, 4'd7, 4'd0};
            default: quad = 16'd0;
        endcase
    endfunction
endpackage

// File: hdl/arx_keystream_xor_cipher.sv
// Top level: ARX keystream XOR byte cipher
// channel   | dir | beat
// s_axis    | in  | tdata: data_in[7:0]; tuser: start_req[0], seek_offset[64:1]; tlast
// m_axis    | out | tdata: data_out[7:0]; tlast
// cfg       | in  | cfg_index[2:0], cfg_data[63:0]
// A byte within a generated block is accepted in idle and emitted from the emit state, which waits on output.
// A byte that needs a new block goes through accept, 128 shuffle steps of the
// shared quad unit, two initial-state adds and emit.
// Reset clears counters; first byte starts at offset 0.
// Output register holds a beat while m_axis_tready is low; the next byte then waits in emit and input stalls.
module arx_keystream_xor_cipher
    import akx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_in
    input  logic [64:0] s_axis_tuser,   // start_req, seek_offset
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // data_out
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0] cfg_data
);
    logic [63:0] key_reg [4];
    logic [63:0] nonce_reg [2];
    logic [31:0] tail_reg;
    logic [7:0] din_reg;
    logic last_reg, ovalid_reg;
    logic [7:0] odata_reg;
    logic olast_reg;
    logic in_fire, cfg_fire, busy, emit, out_free;
    logic [63:0] blk;
    logic [5:0] pos;
    logic [511:0] init_words;
    logic [31:0] word;
    akx_cmd_t cmd;
    akx_status_t status;

    assign s_axis_tready = !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire = cfg_valid && (cfg_index <= REG_NONCE_2);
    assign out_free = !ovalid_reg || m_axis_tready;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = odata_reg;
    assign m_axis_tlast = olast_reg;

    assign init_words = {tail_reg, nonce_reg[1], nonce_reg[0][63:32],
                         nonce_reg[0][31:0] ^ blk[63:32], blk[31:0],
                         key_reg[3], key_reg[2], key_reg[1], key_reg[0],
                         MAGIC_HI, MAGIC_LO};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                key_reg[i] <= 64'd0;
            nonce_reg[0] <= 64'd0;
            nonce_reg[1] <= 64'd0;
            tail_reg <= 32'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_KEY_0: key_reg[0] <= cfg_data;
                    REG_KEY_1: key_reg[1] <= cfg_data;
                    REG_KEY_2: key_reg[2] <= cfg_data;
                    REG_KEY_3: key_reg[3] <= cfg_data;
                    REG_NONCE_0: nonce_reg[0] <= cfg_data;
                    REG_NONCE_1: nonce_reg[1] <= cfg_data;
                    REG_NONCE_2: tail_reg <= cfg_data[31:0];
                    default: ;
                endcase
            end
            if (emit)
                ovalid_reg <= 1'b1;
            else if (m_axis_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            din_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
        if (emit)
        begin
            odata_reg <= din_reg ^ word[{pos[1:0], 3'b000} +: 8];
            olast_reg <= last_reg;
        end
    end

    akx_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .start_req(s_axis_tuser[0]), .seek_offset(s_axis_tuser[64:1]),
        .cfg_fire(cfg_fire), .out_free(out_free), .status(status), .cmd(cmd),
        .busy(busy), .emit(emit), .block_number(blk), .byte_position(pos)
    );

    akx_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .init_words(init_words),
        .word_sel(pos[5:2]), .word_out(word), .status(status)
    );
endmodule

// File: hdl/akx_datapath.sv
// Datapath: state words, shared quad shuffle step unit, initial-state add
module akx_datapath
    import akx_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  akx_cmd_t        cmd,
    input  logic [511:0]    init_words,
    input  logic [3:0]      word_sel,
    output logic [31:0]     word_out,
    output akx_status_t     status
);
    logic [31:0] w_reg [16];
    logic [2:0] step_reg;
    logic [15:0] q;
    logic [3:0] ia, ib, ic, id, dst;
    logic [31:0] a, b, c, d, nv;

    assign q = quad(cmd.shuffle);
    assign ia = q[3:0];
    assign ib = q[7:4];
    assign ic = q[11:8];
    assign id = q[15:12];
    assign a = w_reg[ia];
    assign b = w_reg[ib];
    assign c = w_reg[ic];
    assign d = w_reg[id];

    always_comb
    begin
        case (step_reg)
            3'd0: begin dst = ic; nv = c + rotl((a ^ b) + d, 9); end
            3'd1: begin dst = id; nv = d ^ rotl((b + c) ^ a, 13); end
            3'd2: begin dst = ia; nv = a + rotl((c ^ d) + b, 18); end
            3'd3: begin dst = ib; nv = b ^ rotl((d + a) ^ c, 22); end
            3'd4: begin dst = ic; nv = c ^ rotl(a + b, 7); end
            3'd5: begin dst = id; nv = d + rotl(b ^ c, 21); end
            3'd6: begin dst = ia; nv = a ^ rotl(c + d, 11); end
            3'd7: begin dst = ib; nv = b + rotl(d ^ a, 16); end
            default: begin dst = ia; nv = a; end
        endcase
    end

    assign status.last_step = (step_reg == 3'd7);
    assign status.last_shuffle = (cmd.shuffle[2:0] == 3'd7);
    assign word_out = w_reg[word_sel];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= 3'd0;
        else if (cmd.load)
            step_reg <= 3'd0;
        else if (cmd.step)
            step_reg <= step_reg + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= init_words[32*i +: 32];
        end
        else if (cmd.add_init)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= w_reg[i] + init_words[32*i +: 32];
        end
        else if (cmd.step)
            w_reg[dst] <= nv;
    end
endmodule

// File: hdl/akx_ctrl.sv
// Controller: byte sequencing, block counter, keystream generation sequence
module akx_ctrl
    import akx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_fire,
    input  logic        start_req,
    input  logic [63:0] seek_offset,
    input  logic        cfg_fire,
    input  logic        out_free,
    input  akx_status_t status,
    output akx_cmd_t    cmd,
    output logic        busy,
    output logic        emit,
    output logic [63:0] block_number,
    output logic [5:0]  byte_position
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MIX  = 2'd1;
    localparam logic [1:0] S_ADD  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [3:0] shuf_reg, shuf_next;
    logic [63:0] blk_reg, blk_next;
    logic [5:0] pos_reg, pos_next;
    logic ready_reg, ready_next;

    assign block_number = blk_next;
    assign byte_position = pos_reg;
    assign busy = (state_reg != S_IDLE);
    assign emit = (state_reg == S_EMIT) && out_free;

    always_comb
    begin
        state_next = state_reg;
        shuf_next = shuf_reg;
        blk_next = blk_reg;
        pos_next = pos_reg;
        ready_next = ready_reg;
        cmd.load = 1'b0;
        cmd.step = 1'b0;
        cmd.add_init = 1'b0;
        cmd.shuffle = shuf_reg;
        if (cfg_fire)
            ready_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (start_req)
                    begin
                        blk_next = seek_offset >> 6;
                        pos_next = seek_offset[5:0];
                    end
                    if (start_req || !ready_reg)
                    begin
                        state_next = S_MIX;
                        shuf_next = 4'd0;
                        cmd.load = 1'b1;
                    end
                    else
                        state_next = S_EMIT;
                end
            end
            S_MIX:
            begin
                cmd.step = 1'b1;
                if (status.last_step)
                begin
                    shuf_next = shuf_reg + 4'd1;
                    if (status.last_shuffle)
                        state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.add_init = 1'b1;
                if (shuf_reg == 4'd0)
                begin
                    ready_next = 1'b1;
                    state_next = S_EMIT;
                end
                else
                    state_next = S_MIX;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    pos_next = pos_reg + 6'd1;
                    if (pos_reg == 6'd63)
                    begin
                        blk_next = blk_reg + 64'd1;
                        ready_next = 1'b0;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            shuf_reg <= 4'd0;
            blk_reg <= 64'd0;
            pos_reg <= 6'd0;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            shuf_reg <= shuf_next;
            blk_reg <= blk_next;
            pos_reg <= pos_next;
            ready_reg <= ready_next;
        end
    end

    `include "arx_keystream_xor_cipher_macros.svh"
    `AKX_ASSERT_IMP(a_load_idle, cmd.load, state_reg == S_IDLE)
    `AKX_ASSERT_IMP(a_emit_ready, state_reg == S_EMIT, ready_reg)
    `AKX_ASSERT_NEXT(a_wrap_block, emit && pos_reg == 6'd63, blk_reg == $past(blk_reg) + 64'd1)
endmodule

// File: sim/arx_keystream_xor_cipher_tb.sv
// Self-checking testbench for arx_keystream_xor_cipher: directed and random byte streams
module arx_keystream_xor_cipher_tb;
    import akx_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 5000;
    localparam int ALL_DONE_WAIT = 200;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } cipher_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [64:0] s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0] cfg_data;

    logic [63:0] key_reg [4];
    logic [63:0] nonce_reg [2];
    logic [31:0] nonce_tail_reg;
    logic [31:0] ks_word [16];
    logic [63:0] blk_num;
    logic [5:0]  byte_pos;
    logic        ks_valid;

    cipher_beat_t cipher_out_q[$];
    int  fail_count;
    int  quiet_cycles;
    int  hold_cycles;
    bit  idle_on;

    arx_keystream_xor_cipher DUT (.*);

    always #4 clk = ~clk;

    function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void shuffle_quad(ref logic [31:0] w[16], input int a, input int b,
                                         input int c, input int d);
        w[c] = w[c] + rol32((w[a] ^ w[b]) + w[d], 9);
        w[d] = w[d] ^ rol32((w[b] + w[c]) ^ w[a], 13);
        w[a] = w[a] + rol32((w[c] ^ w[d]) + w[b], 18);
        w[b] = w[b] ^ rol32((w[d] + w[a]) ^ w[c], 22);
        w[c] = w[c] ^ rol32(w[a] + w[b], 7);
        w[d] = w[d] + rol32(w[b] ^ w[c], 21);
        w[a] = w[a] ^ rol32(w[c] + w[d], 11);
        w[b] = w[b] + rol32(w[d] ^ w[a], 16);
    endfunction

    function automatic void generate_keystream();
        logic [31:0] init_w [16];
        logic [31:0] w [16];
        int r1 [8][4];
        int r2 [8][4];
        r1 = '{'{0, 1, 2, 3}, '{4, 5, 6, 7}, '{8, 9, 10, 11}, '{12, 13, 14, 15},
               '{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7, 8, 13}, '{3, 4, 9, 14}};
        r2 = '{'{0, 4, 8, 12}, '{1, 5, 9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
               '{3, 6, 9, 12}, '{2, 5, 8, 15}, '{1, 4, 11, 14}, '{0, 7, 10, 13}};
        init_w[0] = MAGIC_LO;
        init_w[1] = MAGIC_HI;
        for (int i = 0; i < 4; i++)
        begin
            init_w[2 + 2 * i] = key_reg[i][31:0];
            init_w[3 + 2 * i] = key_reg[i][63:32];
        end
        init_w[10] = blk_num[31:0];
        init_w[11] = nonce_reg[0][31:0] ^ blk_num[63:32];
        init_w[12] = nonce_reg[0][63:32];
        init_w[13] = nonce_reg[1][31:0];
        init_w[14] = nonce_reg[1][63:32];
        init_w[15] = nonce_tail_reg;
        w = init_w;
        for (int i = 0; i < 8; i++)
            shuffle_quad(w, r1[i][0], r1[i][1], r1[i][2], r1[i][3]);
        for (int i = 0; i < 16; i++)
            w[i] = w[i] + init_w[i];
        for (int i = 0; i < 8; i++)
            shuffle_quad(w, r2[i][0], r2[i][1], r2[i][2], r2[i][3]);
        for (int i = 0; i < 16; i++)
            ks_word[i] = w[i] + init_w[i];
        ks_valid = 1'b1;
    endfunction

    function automatic cipher_beat_t encrypt_byte(input logic [7:0] data, input logic start,
                                                  input logic [63:0] offset, input logic last);
        cipher_beat_t r;
        if (start)
        begin
            blk_num  = offset >> 6;
            byte_pos = offset[5:0];
            generate_keystream();
        end
        else if (!ks_valid)
            generate_keystream();
        r.data = data ^ ks_word[byte_pos[5:2]][byte_pos[1:0] * 8 +: 8];
        r.last = last;
        if (byte_pos == 6'd63)
        begin
            blk_num  = blk_num + 64'd1;
            ks_valid = 1'b0;
        end
        byte_pos = byte_pos + 6'd1;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic start,
                             input logic [63:0] offset, input logic last);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 8)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = data;
        s_axis_tuser  = {offset, start};
        s_axis_tlast  = last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        cipher_out_q.push_back(encrypt_byte(data, start, offset, last));
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (cipher_out_q.size() != 0)
            @(posedge clk);
        repeat (ALL_DONE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3: key_reg[idx[1:0]] = value;
            REG_NONCE_0, REG_NONCE_1: nonce_reg[idx[0]] = value;
            REG_NONCE_2: nonce_tail_reg = value[31:0];
            default: ;
        endcase
        if (idx != REG_UNUSED)
            ks_valid = 1'b0;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(input logic [63:0] fill);
        write_reg(REG_KEY_0, fill);
        write_reg(REG_KEY_1, ~fill);
        write_reg(REG_KEY_2, fill);
        write_reg(REG_KEY_3, fill);
        write_reg(REG_NONCE_0, fill);
        write_reg(REG_NONCE_1, ~fill);
        write_reg(REG_NONCE_2, fill);
    endtask

    task automatic write_random();
        write_reg(REG_KEY_0, {$urandom, $urandom});
        write_reg(REG_KEY_1, {$urandom, $urandom});
        write_reg(REG_KEY_2, {$urandom, $urandom});
        write_reg(REG_KEY_3, {$urandom, $urandom});
        write_reg(REG_NONCE_0, {$urandom, $urandom});
        write_reg(REG_NONCE_1, {$urandom, $urandom});
        write_reg(REG_NONCE_2, {$urandom, $urandom});
    endtask

    task automatic test_reset_stream();
        for (int i = 0; i < 70; i++)
            send_byte(8'(i), 1'b0, 64'd0, i == 69);
        drain();
    endtask

    task automatic test_offsets();
        send_byte(8'h00, 1'b1, 64'd0, 1'b0);
        send_byte(8'hFF, 1'b1, 64'd63, 1'b0);
        send_byte(8'hA5, 1'b0, 64'd0, 1'b1);
        send_byte(8'h5A, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_byte(8'h3C, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_byte(8'hC3, 1'b1, 64'h0000_003F_FFFF_FFFF, 1'b0);
        send_byte(8'h81, 1'b0, 64'd0, 1'b0);
        drain();
    endtask

    task automatic test_config();
        write_all(64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(8'h11, 1'b1, 64'd5, 1'b0);
        send_byte(8'h22, 1'b0, 64'd0, 1'b1);
        drain();
        write_reg(REG_KEY_2, 64'h0123_4567_89AB_CDEF);
        send_byte(8'h33, 1'b0, 64'd0, 1'b0);
        drain();
        write_reg(REG_UNUSED, 64'hDEAD_BEEF_0000_0001);
        send_byte(8'h44, 1'b0, 64'd0, 1'b1);
        drain();
        write_all(64'd0);
        send_byte(8'h55, 1'b1, 64'd100, 1'b0);
        drain();
    endtask

    task automatic test_random_streams(input int n_bytes);
        int sent;
        int run_len;
        logic [63:0] off;
        sent = 0;
        while (sent < n_bytes)
        begin
            if ($urandom_range(3) == 0)
            begin
                drain();
                write_random();
            end
            idle_on = ($urandom_range(4) != 0);
            run_len = $urandom_range(1, 90);
            case ($urandom_range(3))
                0: off = {$urandom, $urandom};
                1: off = {32'hFFFF_FFFF, $urandom};
                default: off = 64'($urandom_range(300));
            endcase
            for (int i = 0; i < run_len; i++)
                send_byte(8'($urandom), i == 0 ? 1'b1 : ($urandom_range(40) == 0),
                          {$urandom, $urandom} & (i == 0 ? 64'hFFFF_FFFF_FFFF_FFFF : off) |
                          (i == 0 ? off : 64'd0), i == run_len - 1);
            sent += run_len;
        end
        idle_on = 1'b1;
        drain();
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 40; i++)
            send_byte(8'($urandom), i == 0, 64'd60, i == 39);
        drain();
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles = hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= !(idle_on && $urandom_range(99) < 8);
    end

    always @(posedge clk)
    begin
        cipher_beat_t exp_beat;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (cipher_out_q.size() == 0)
            begin
                $error("unexpected beat: data_out %h last_out %b", m_axis_tdata, m_axis_tlast);
                fail_count++;
            end
            else
            begin
                exp_beat = cipher_out_q.pop_front();
                if (m_axis_tdata !== exp_beat.data)
                begin
                    $error("data_out expected %h actual %h", exp_beat.data, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tlast !== exp_beat.last)
                begin
                    $error("last_out expected %b actual %b", exp_beat.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("arx_keystream_xor_cipher test failed");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_KEY_0;
        cfg_data = '0;
        fail_count = 0;
        quiet_cycles = 0;
        hold_cycles = 0;
        idle_on = 1'b0;
        key_reg = '{default: '0};
        nonce_reg = '{default: '0};
        nonce_tail_reg = '0;
        ks_word = '{default: '0};
        blk_num = '0;
        byte_pos = '0;
        ks_valid = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_stream();
        idle_on = 1'b1;
        test_offsets();
        test_config();
        test_backpressure();
        test_random_streams(1800);
        if (fail_count == 0)
            $display("arx_keystream_xor_cipher test passed");
        else
            $display("arx_keystream_xor_cipher test failed");
        $finish;
    end
endmodule
